// File: rtl/core/sha256_message_hasher_defines.svh
// assertion macros used by the hasher checker file
`ifndef SHA256_MESSAGE_HASHER_DEFINES_SVH
`define SHA256_MESSAGE_HASHER_DEFINES_SVH

// clocked check, held off while reset is active
`define SMH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define SMH_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/sha256mh_pkg.sv
// types, constants and functions of the sha-256 message hasher
package sha256mh_pkg;

	// input item
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       last_byte;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// control from sequencer to schedule memory unit
	typedef struct packed {
		logic        start;
		logic        wr_en;
		logic [3:0]  wr_addr;
		logic [31:0] wr_data;
	} sched_ctl_t;

	// schedule word handed to the round unit
	typedef struct packed {
		logic        valid;
		logic        last;
		logic [31:0] wk;
	} sched_out_t;

	// control from sequencer to round unit
	typedef struct packed {
		logic       load;
		logic       reinit;
		logic [2:0] rd_idx;
	} rnd_ctl_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] HASH_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

endpackage

// File: rtl/core/sha256mh_sched.sv
// block and message schedule store: two mirrored 16-word memories, w expansion
module sha256mh_sched import sha256mh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  sched_ctl_t ctl,
	output sched_out_t sout
);

	logic [31:0] mem_a [16];
	logic [31:0] mem_b [16];

	logic        act_q;
	logic [5:0]  cnt_q;
	logic        v_s1;
	logic [5:0]  j_s1;
	logic [31:0] w16_s1, w15_s1, w7_s1, w2_s1;
	logic        v_s2;
	logic        last_s2;
	logic [31:0] wk_s2;

	logic [3:0]  a0_addr, a1_addr, b0_addr, b1_addr;
	logic [31:0] w_new;
	logic        sw_en;
	logic        wr_en;
	logic [3:0]  wr_addr;
	logic [31:0] wr_data;

	// read addresses for word cnt_q: w[j-16], w[j-15], w[j-7], w[j-2]
	assign a0_addr = cnt_q[3:0];
	assign a1_addr = cnt_q[3:0] + 4'd1;
	assign b0_addr = cnt_q[3:0] + 4'd9;
	assign b1_addr = cnt_q[3:0] + 4'd14;

	// expansion of one schedule word
	always_comb begin
		if (j_s1[5:4] == 2'b00) begin
			w_new = w16_s1;
		end else begin
			w_new = w16_s1 + small_sigma0(w15_s1) + w7_s1 + small_sigma1(w2_s1);
		end
	end

	// expanded words go back to the store, otherwise the sequencer writes
	assign sw_en   = v_s1 && (j_s1[5:4] != 2'b00);
	assign wr_en   = sw_en || ctl.wr_en;
	assign wr_addr = sw_en ? j_s1[3:0] : ctl.wr_addr;
	assign wr_data = sw_en ? w_new : ctl.wr_data;

	// memories with registered reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_a[wr_addr] <= wr_data;
			mem_b[wr_addr] <= wr_data;
		end
		w16_s1 <= mem_a[a0_addr];
		w15_s1 <= mem_a[a1_addr];
		w7_s1  <= mem_b[b0_addr];
		w2_s1  <= mem_b[b1_addr];
	end

	// issue counter and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			cnt_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			if (ctl.start) begin
				act_q <= 1'b1;
				cnt_q <= '0;
			end else if (act_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					act_q <= 1'b0;
				end
			end
			v_s1 <= act_q;
			v_s2 <= v_s1;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		j_s1    <= cnt_q;
		wk_s2   <= w_new + ROUND_K[j_s1];
		last_s2 <= (j_s1 == 6'd63);
	end

	assign sout.valid = v_s2;
	assign sout.last  = last_s2;
	assign sout.wk    = wk_s2;

endmodule

// File: rtl/core/sha256mh_round.sv
// compression rounds, working variables and chaining hash words
module sha256mh_round import sha256mh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  sched_out_t  sin,
	input  rnd_ctl_t    ctl,
	output logic        done,
	output logic [31:0] hash_word
);

	logic [31:0] hash_q [8];
	logic [31:0] v_q [8];
	logic        fin_q;

	logic [31:0] t1, t2, ch, maj;

	// one round
	always_comb begin
		ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1  = v_q[7] + big_sigma1(v_q[4]) + ch + sin.wk;
		t2  = big_sigma0(v_q[0]) + maj;
	end

	// working variables
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			v_q <= hash_q;
		end else if (sin.valid) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	// chaining value: feed-forward after round 63, back to iv after a digest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HASH_IV;
			fin_q  <= 1'b0;
		end else begin
			fin_q <= sin.valid && sin.last;
			if (ctl.reinit) begin
				hash_q <= HASH_IV;
			end else if (fin_q) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= hash_q[i] + v_q[i];
				end
			end
		end
	end

	assign done      = fin_q;
	assign hash_word = hash_q[ctl.rd_idx];

endmodule

// File: rtl/core/sha256_message_hasher.sv
// sha-256 message hasher top level: byte intake, padding sequencer, digest output
//
// Input channel in_valid/in_ready/in_data carries one message byte per item
// (byte_present) and marks the end of a message with last_byte; a last item
// may carry no byte. Output channel out_valid/out_ready/out_data returns the
// eight digest words of a message, word_index 0 first, last_word on word 7.
// Byte items are taken while the sequencer is idle. The byte that completes a
// 64-byte block holds the input while the block is compressed: one round per
// cycle, limited by the single round unit and by the four schedule reads per
// round from the two mirrored schedule memories. A last item adds padding
// writes (one word per cycle, paused while a block is compressed, up to 18),
// one or two compressions and the output of the eight digest words. A stalled
// output holds its word in the output register; the remaining words wait.
// After the eighth word is loaded the block takes new bytes while that word
// still waits. Reset returns the hash state to the initial values and the
// byte count to zero; the block is ready at once.
module sha256_message_hasher import sha256mh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_COMP  = 3'd1;
	localparam logic [2:0] ST_PAD0  = 3'd2;
	localparam logic [2:0] ST_FILL  = 3'd3;
	localparam logic [2:0] ST_LEN14 = 3'd4;
	localparam logic [2:0] ST_LEN15 = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0]  state_q, state_d;
	logic [2:0]  ret_q, ret_d;
	logic [60:0] len_q, len_d;
	logic [23:0] acc_q, acc_d;
	logic [3:0]  pad_addr_q, pad_addr_d;
	logic        extra_q, extra_d;
	logic [2:0]  oidx_q, oidx_d;
	logic        out_valid_q;
	out_item_t   out_q;

	sched_ctl_t  sctl;
	sched_out_t  sout;
	rnd_ctl_t    rctl;
	logic        comp_done;
	logic [31:0] hash_word;

	logic        acc_fire;
	logic        out_load;
	logic [63:0] bit_len;
	logic [31:0] pad_word;

	assign in_ready = (state_q == ST_IDLE);
	assign acc_fire = in_valid && in_ready;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	assign bit_len  = {len_q, 3'b000};

	// word holding the pad byte after the bytes already collected
	always_comb begin
		case (len_q[1:0])
			2'd0:    pad_word = {PAD_BYTE, 24'h000000};
			2'd1:    pad_word = {acc_q[7:0], PAD_BYTE, 16'h0000};
			2'd2:    pad_word = {acc_q[15:0], PAD_BYTE, 8'h00};
			default: pad_word = {acc_q[23:0], PAD_BYTE};
		endcase
	end

	// sequencer
	always_comb begin
		state_d      = state_q;
		ret_d        = ret_q;
		len_d        = len_q;
		acc_d        = acc_q;
		pad_addr_d   = pad_addr_q;
		extra_d      = extra_q;
		oidx_d       = oidx_q;
		sctl         = '0;
		rctl         = '0;
		rctl.rd_idx  = oidx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc_fire) begin
					if (in_data.byte_present) begin
						acc_d = {acc_q[15:0], in_data.data_byte};
						len_d = len_q + 61'd1;
						if (len_q[1:0] == 2'd3) begin
							sctl.wr_en   = 1'b1;
							sctl.wr_addr = len_q[5:2];
							sctl.wr_data = {acc_q, in_data.data_byte};
						end
					end
					if (in_data.byte_present && (len_q[5:0] == 6'd63)) begin
						sctl.start = 1'b1;
						rctl.load  = 1'b1;
						state_d    = ST_COMP;
						ret_d      = in_data.last_byte ? ST_PAD0 : ST_IDLE;
					end else if (in_data.last_byte) begin
						state_d = ST_PAD0;
					end
				end
			end
			ST_COMP: begin
				if (comp_done) begin
					state_d = ret_q;
				end
			end
			ST_PAD0: begin
				sctl.wr_en   = 1'b1;
				sctl.wr_addr = len_q[5:2];
				sctl.wr_data = pad_word;
				pad_addr_d   = len_q[5:2] + 4'd1;
				extra_d      = (len_q[5:2] == 4'd14);
				if (len_q[5:2] == 4'd13) begin
					state_d = ST_LEN14;
				end else if (len_q[5:2] == 4'd15) begin
					// pad byte closes the block: length goes in a block of its own
					sctl.start = 1'b1;
					rctl.load  = 1'b1;
					pad_addr_d = '0;
					extra_d    = 1'b0;
					state_d    = ST_COMP;
					ret_d      = ST_FILL;
				end else begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				sctl.wr_en   = 1'b1;
				sctl.wr_addr = pad_addr_q;
				sctl.wr_data = '0;
				if (extra_q) begin
					sctl.start = 1'b1;
					rctl.load  = 1'b1;
					pad_addr_d = '0;
					extra_d    = 1'b0;
					state_d    = ST_COMP;
					ret_d      = ST_FILL;
				end else if (pad_addr_q == 4'd13) begin
					state_d = ST_LEN14;
				end else begin
					pad_addr_d = pad_addr_q + 4'd1;
				end
			end
			ST_LEN14: begin
				sctl.wr_en   = 1'b1;
				sctl.wr_addr = 4'd14;
				sctl.wr_data = bit_len[63:32];
				state_d      = ST_LEN15;
			end
			ST_LEN15: begin
				sctl.wr_en   = 1'b1;
				sctl.wr_addr = 4'd15;
				sctl.wr_data = bit_len[31:0];
				sctl.start   = 1'b1;
				rctl.load    = 1'b1;
				oidx_d       = '0;
				state_d      = ST_COMP;
				ret_d        = ST_OUT;
			end
			ST_OUT: begin
				if (out_load) begin
					oidx_d = oidx_q + 3'd1;
					if (oidx_q == 3'd7) begin
						rctl.reinit = 1'b1;
						len_d       = '0;
						state_d     = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			len_q       <= '0;
			pad_addr_q  <= '0;
			extra_q     <= 1'b0;
			oidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			ret_q      <= ret_d;
			len_q      <= len_d;
			pad_addr_q <= pad_addr_d;
			extra_q    <= extra_d;
			oidx_q     <= oidx_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		acc_q <= acc_d;
		if (out_load) begin
			out_q.digest_word <= hash_word;
			out_q.word_index  <= oidx_q;
			out_q.last_word   <= (oidx_q == 3'd7);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	sha256mh_sched u_sched (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sctl),
		.sout   (sout)
	);

	sha256mh_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.sin       (sout),
		.ctl       (rctl),
		.done      (comp_done),
		.hash_word (hash_word)
	);

endmodule

// File: rtl/core/sha256mh_checker.sv
// port-level checks of the hasher and their binding to the top level
`include "sha256_message_hasher_defines.svh"

module sha256mh_checker import sha256mh_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// a waiting digest word holds
	`SMH_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "digest word changed while stalled")

	// last flag marks exactly word 7
	`SMH_ASSERT(a_last_flag, out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)), "last_word does not match word_index")

	// closing a message stops intake while padding runs
	`SMH_ASSERT(a_close_busy, in_valid && in_ready && in_data.last_byte |=> !in_ready, "input taken right after a last item")

	// nothing is offered once a reset edge has been seen
	`SMH_ASSERT_ALWAYS(a_rst_quiet, !arst_n |=> !out_valid, "output valid after a reset edge")

endmodule

bind sha256_message_hasher sha256mh_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
